>>> rtl/twes_pkg.sv
// types, codes and widths shared by the timing wheel scheduler core and its checker
// no dependencies

package twes_pkg;

   localparam int ID_W     = 6;
   localparam int DELAY_W  = 10;
   localparam int REM_W    = 9;
   localparam int STATUS_W = 3;
   localparam int CMD_W    = 2;
   localparam int LINK_W   = 7;

   localparam int WHEEL_SLOTS_DEF = 256;
   localparam int EVENT_COUNT_DEF = 64;

   localparam logic [LINK_W-1:0] LINK_NONE = 7'd127;

   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_CANCEL   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_QUERY    = 2'd3;

   localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_BUSY     = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_CLAMPED  = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_EXPIRED  = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_NONE_DUE = 3'd4;

   typedef struct packed {
      logic [CMD_W-1:0]   cmd;
      logic [ID_W-1:0]    event_id;
      logic [DELAY_W-1:0] delay;
   } req_word_type;

   typedef struct packed {
      logic [ID_W-1:0]     event_id_res;
      logic [STATUS_W-1:0] status;
      logic [REM_W-1:0]    remaining;
      logic                last;
   } rsp_word_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCHED,
      ST_CAN_EV,
      ST_CAN_HEAD,
      ST_CAN_WALK,
      ST_TICK_HEAD,
      ST_TICK_DRAIN,
      ST_QUERY
   } state_type;

endpackage

>>> rtl/timing_wheel_event_scheduler_core.sv
// timing wheel event scheduler: slot head memory, event link memory and sequencer
// depends on twes_pkg
//
// usage
//   req channel takes one command word (schedule, cancel, tick, query) when
//   req_valid is high and req_stall is low. rsp channel delivers result words
//   on rsp_valid while rsp_stall is low; the final word of a command has last set.
//   one command is worked on at a time; req_stall is high while it is in flight.
// sequence
//   schedule, query: one memory read at accept, then the result word is loaded
//   cancel: the event entry is read; an idle event is answered from it, else its
//   slot head is read and the list is walked as needed, one event memory read per link
//   tick: slot head read; an empty slot gives a none-due word, else one word per
//   expired event, one per cycle while rsp_stall is low, paced by the next link's read
// reset
//   synchronous; afterwards the slot head memory is swept to empty, one
//   entry per cycle, with req_stall high until the sweep ends
// stall
//   the result register holds its word while rsp_stall is high; the
//   sequencer waits wherever it would load a word, and the memories keep their read data

module timing_wheel_event_scheduler_core #(
   parameter int WHEEL_SLOTS = twes_pkg::WHEEL_SLOTS_DEF,
   parameter int EVENT_COUNT = twes_pkg::EVENT_COUNT_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  twes_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output twes_pkg::rsp_word_type rsp_word
);

   localparam int SLOT_W  = $clog2(WHEEL_SLOTS);
   localparam int EV_W    = $clog2(EVENT_COUNT);
   localparam int LINK_W  = twes_pkg::LINK_W;
   localparam int ID_W    = twes_pkg::ID_W;
   localparam int ENT_W   = LINK_W + SLOT_W;
   localparam int SUM_W   = SLOT_W + 2;
   localparam int DLY_W   = (SUM_W > twes_pkg::DELAY_W) ? SUM_W : twes_pkg::DELAY_W;

   localparam logic [LINK_W-1:0] LINK_LIM  = LINK_W'(EVENT_COUNT);
   localparam logic [DLY_W-1:0]  WS_DLY    = DLY_W'(WHEEL_SLOTS);
   localparam logic [SUM_W-1:0]  WS_SUM    = SUM_W'(WHEEL_SLOTS);
   localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WHEEL_SLOTS - 1);

   // memories
   logic [LINK_W-1:0] slot_head_ff [WHEEL_SLOTS];
   logic [ENT_W-1:0]  event_ff     [EVENT_COUNT];
   logic [LINK_W-1:0] slot_rd_ff;
   logic [ENT_W-1:0]  event_rd_ff;

   logic              sh_we, sh_re, ev_we, ev_re;
   logic [SLOT_W-1:0] sh_wa, sh_ra;
   logic [LINK_W-1:0] sh_wd;
   logic [EV_W-1:0]   ev_wa, ev_ra;
   logic [ENT_W-1:0]  ev_wd;

   // control and working registers
   twes_pkg::state_type          state_ff, state_in;
   logic [SLOT_W-1:0]            cur_ff, cur_in;
   logic [SLOT_W-1:0]            clr_ff, clr_in;
   logic [EVENT_COUNT-1:0]       pend_ff, pend_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   twes_pkg::rsp_word_type       rsp_word_ff, rsp_word_in;
   logic [ID_W-1:0]              id_ff, id_in;
   logic [SLOT_W-1:0]            pos_ff, pos_in;
   logic                         clamp_ff, clamp_in;
   logic [ID_W-1:0]              walk_ff, walk_in;
   logic [LINK_W-1:0]            link_ff, link_in;
   logic [SLOT_W-1:0]            tslot_ff, tslot_in;

   logic                   accept, out_free, rsp_load;
   logic                   pend_set, pend_clr;
   logic [EV_W-1:0]        pend_idx;
   logic                   advance;
   twes_pkg::rsp_word_type rsp_next;

   logic                   id_ok, id_pend;
   logic [LINK_W-1:0]      head, nl;
   logic                   head_ok, head_hit, nl_ok, nl_hit;
   logic [DLY_W-1:0]       dly_ext, dly_sel;
   logic                   req_clamp;
   logic [SUM_W-1:0]       pos_sum, pos_wrap;
   logic [SLOT_W-1:0]      req_pos;
   logic [SUM_W-1:0]       rem_sum, rem_wrap;
   logic [twes_pkg::REM_W-1:0] rem_val;

   assign req_stall = (state_ff != twes_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   assign id_ok    = LINK_W'(id_ff) < LINK_LIM;
   assign id_pend  = id_ok && pend_ff[id_ff[EV_W-1:0]];
   assign head     = slot_rd_ff;
   assign head_ok  = head < LINK_LIM;
   assign head_hit = head == LINK_W'(id_ff);
   assign nl       = event_rd_ff[ENT_W-1:SLOT_W];
   assign nl_ok    = nl < LINK_LIM;
   assign nl_hit   = nl == LINK_W'(id_ff);

   // target slot of a schedule
   assign dly_ext   = DLY_W'(req_word.delay);
   assign req_clamp = dly_ext > WS_DLY;
   assign dly_sel   = req_clamp ? WS_DLY : dly_ext;
   assign pos_sum   = SUM_W'(cur_ff) + SUM_W'(dly_sel);
   assign pos_wrap  = (pos_sum >= WS_SUM) ? (pos_sum - WS_SUM) : pos_sum;
   assign req_pos   = pos_wrap[SLOT_W-1:0];

   // ticks remaining
   assign rem_sum  = SUM_W'(event_rd_ff[SLOT_W-1:0]) + WS_SUM - SUM_W'(cur_ff);
   assign rem_wrap = (rem_sum >= WS_SUM) ? (rem_sum - WS_SUM) : rem_sum;
   assign rem_val  = id_pend ? twes_pkg::REM_W'(rem_wrap)
                             : twes_pkg::REM_W'(WHEEL_SLOTS + 1);

   always_ff @(posedge clock) begin
      if (sh_we) begin
         slot_head_ff[sh_wa] <= sh_wd;
      end
      if (sh_re) begin
         slot_rd_ff <= slot_head_ff[sh_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ev_we) begin
         event_ff[ev_wa] <= ev_wd;
      end
      if (ev_re) begin
         event_rd_ff <= event_ff[ev_ra];
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         twes_pkg::ST_CLEAR: begin
            if (clr_ff == SLOT_LAST) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_IDLE: begin
            if (accept) begin
               case (req_word.cmd)
                  twes_pkg::CMD_SCHEDULE: state_in = twes_pkg::ST_SCHED;
                  twes_pkg::CMD_CANCEL:   state_in = twes_pkg::ST_CAN_EV;
                  twes_pkg::CMD_TICK:     state_in = twes_pkg::ST_TICK_HEAD;
                  default:                state_in = twes_pkg::ST_QUERY;
               endcase
            end
         end
         twes_pkg::ST_SCHED: begin
            if (out_free) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_CAN_EV: begin
            if (id_pend) state_in = twes_pkg::ST_CAN_HEAD;
            else if (out_free) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_CAN_HEAD: begin
            if (head_ok && !head_hit) state_in = twes_pkg::ST_CAN_WALK;
            else if (out_free) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_CAN_WALK: begin
            if ((nl_hit || !nl_ok) && out_free) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_TICK_HEAD: begin
            if (head_ok) state_in = twes_pkg::ST_TICK_DRAIN;
            else if (out_free) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_TICK_DRAIN: begin
            if (out_free && !nl_ok) state_in = twes_pkg::ST_IDLE;
         end
         twes_pkg::ST_QUERY: begin
            if (out_free) state_in = twes_pkg::ST_IDLE;
         end
         default: state_in = twes_pkg::ST_CLEAR;
      endcase
   end

   // datapath and memory control
   always_comb begin
      sh_we    = 1'b0;
      sh_wa    = cur_ff;
      sh_wd    = twes_pkg::LINK_NONE;
      sh_re    = 1'b0;
      sh_ra    = cur_ff;
      ev_we    = 1'b0;
      ev_wa    = walk_ff[EV_W-1:0];
      ev_wd    = {link_ff, event_rd_ff[SLOT_W-1:0]};
      ev_re    = 1'b0;
      ev_ra    = nl[EV_W-1:0];
      rsp_load = 1'b0;
      rsp_next = '0;
      pend_set = 1'b0;
      pend_clr = 1'b0;
      pend_idx = id_ff[EV_W-1:0];
      advance  = 1'b0;
      clr_in   = clr_ff;
      id_in    = id_ff;
      pos_in   = pos_ff;
      clamp_in = clamp_ff;
      walk_in  = walk_ff;
      link_in  = link_ff;
      tslot_in = tslot_ff;
      rsp_next.event_id_res = id_ff;
      rsp_next.last         = 1'b1;
      case (state_ff)
         twes_pkg::ST_CLEAR: begin
            sh_we  = 1'b1;
            sh_wa  = clr_ff;
            clr_in = clr_ff + SLOT_W'(1);
         end
         twes_pkg::ST_IDLE: begin
            if (accept) begin
               id_in    = req_word.event_id;
               pos_in   = req_pos;
               clamp_in = req_clamp;
               ev_ra    = req_word.event_id[EV_W-1:0];
               case (req_word.cmd)
                  twes_pkg::CMD_SCHEDULE: begin
                     sh_re = 1'b1;
                     sh_ra = req_pos;
                  end
                  twes_pkg::CMD_TICK: begin
                     sh_re = 1'b1;
                  end
                  default: begin
                     ev_re = 1'b1;
                  end
               endcase
            end
         end
         twes_pkg::ST_SCHED: begin
            if (out_free) begin
               rsp_load = 1'b1;
               if (!id_ok || id_pend) begin
                  rsp_next.status = twes_pkg::STAT_BUSY;
               end else begin
                  sh_we    = 1'b1;
                  sh_wa    = pos_ff;
                  sh_wd    = LINK_W'(id_ff);
                  ev_we    = 1'b1;
                  ev_wa    = id_ff[EV_W-1:0];
                  ev_wd    = {slot_rd_ff, pos_ff};
                  pend_set = 1'b1;
                  rsp_next.status = clamp_ff ? twes_pkg::STAT_CLAMPED : twes_pkg::STAT_OK;
               end
            end
         end
         twes_pkg::ST_CAN_EV: begin
            if (id_pend) begin
               link_in  = nl;
               tslot_in = event_rd_ff[SLOT_W-1:0];
               sh_re    = 1'b1;
               sh_ra    = event_rd_ff[SLOT_W-1:0];
            end else if (out_free) begin
               rsp_load = 1'b1;
               rsp_next.status = id_ok ? twes_pkg::STAT_OK : twes_pkg::STAT_BUSY;
            end
         end
         twes_pkg::ST_CAN_HEAD: begin
            if (head_ok && !head_hit) begin
               walk_in = head[ID_W-1:0];
               ev_re   = 1'b1;
               ev_ra   = head[EV_W-1:0];
            end else if (out_free) begin
               sh_we    = head_hit;
               sh_wa    = tslot_ff;
               sh_wd    = link_ff;
               pend_clr = 1'b1;
               rsp_load = 1'b1;
               rsp_next.status = twes_pkg::STAT_OK;
            end
         end
         twes_pkg::ST_CAN_WALK: begin
            if (nl_hit || !nl_ok) begin
               if (out_free) begin
                  ev_we    = nl_hit;
                  pend_clr = 1'b1;
                  rsp_load = 1'b1;
                  rsp_next.status = twes_pkg::STAT_OK;
               end
            end else begin
               walk_in = nl[ID_W-1:0];
               ev_re   = 1'b1;
            end
         end
         twes_pkg::ST_TICK_HEAD: begin
            if (head_ok) begin
               walk_in = head[ID_W-1:0];
               ev_re   = 1'b1;
               ev_ra   = head[EV_W-1:0];
            end else if (out_free) begin
               rsp_load = 1'b1;
               advance  = 1'b1;
               rsp_next.event_id_res = '0;
               rsp_next.status       = twes_pkg::STAT_NONE_DUE;
            end
         end
         twes_pkg::ST_TICK_DRAIN: begin
            if (out_free) begin
               rsp_load = 1'b1;
               pend_clr = 1'b1;
               pend_idx = walk_ff[EV_W-1:0];
               rsp_next.event_id_res = walk_ff;
               rsp_next.status       = twes_pkg::STAT_EXPIRED;
               rsp_next.last         = !nl_ok;
               if (nl_ok) begin
                  walk_in = nl[ID_W-1:0];
                  ev_re   = 1'b1;
               end else begin
                  sh_we   = 1'b1;
                  advance = 1'b1;
               end
            end
         end
         twes_pkg::ST_QUERY: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_next.status    = twes_pkg::STAT_OK;
               rsp_next.remaining = rem_val;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      pend_in = pend_ff;
      if (pend_set) pend_in[pend_idx] = 1'b1;
      if (pend_clr) pend_in[pend_idx] = 1'b0;
      cur_in = cur_ff;
      if (advance) cur_in = (cur_ff == SLOT_LAST) ? '0 : cur_ff + SLOT_W'(1);
      rsp_word_in  = rsp_load ? rsp_next : rsp_word_ff;
      rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= twes_pkg::ST_CLEAR;
         clr_ff       <= '0;
         cur_ff       <= '0;
         pend_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         cur_ff       <= cur_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
      id_ff       <= id_in;
      pos_ff      <= pos_in;
      clamp_ff    <= clamp_in;
      walk_ff     <= walk_in;
      link_ff     <= link_in;
      tslot_ff    <= tslot_in;
   end

endmodule

>>> rtl/twes_checker.sv
// port-level checks for the timing wheel scheduler core, bound to the core
// depends on twes_pkg and timing_wheel_event_scheduler_core

module twes_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input twes_pkg::req_word_type req_word,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input twes_pkg::rsp_word_type rsp_word
);

   // one command at a time: busy right after an accept
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted while previous command in flight");

   // clearing pass keeps the input closed after reset
   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> req_stall)
      else $error("req open during clearing pass");

   // a tick still draining keeps the input closed
   a_drain_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.last |-> req_stall)
      else $error("req open before final rsp word");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("stalled rsp word changed");

endmodule

bind timing_wheel_event_scheduler_core twes_checker u_twes_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_word  (req_word),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);
